### rtl/core/assert_macros.svh
// assertion macros shared by the lock rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define KPL_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define KPL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/kpl_pkg.sv
// types, constants and key decode table for the keypad pin lock
package kpl_pkg;

    localparam int NUM_DIGITS = 6;
    localparam int KEY_W      = 5;
    localparam int DIGIT_W    = 4;
    localparam int COUNT_W    = 3;
    localparam int CHECK_W    = 2;
    localparam int REG_IDX_W  = 3;

    typedef logic [KEY_W-1:0]     key_t;
    typedef logic [DIGIT_W-1:0]   digit_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [CHECK_W-1:0]   check_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    // six digits, entry 0 is the first digit
    typedef digit_t [NUM_DIGITS-1:0] code_t;

    typedef struct packed {
        logic   hit;
        digit_t value;
    } digit_sel_t;

    // press beat handed from the edge stage to the lock core
    typedef struct packed {
        logic valid;
        key_t press;
    } press_beat_t;

    localparam key_t KEY_CLEAR = 5'd13;
    localparam key_t KEY_CHECK = 5'd16;

    localparam check_t CHECK_NONE   = 2'd0;
    localparam check_t CHECK_ACCEPT = 2'd1;
    localparam check_t CHECK_REJECT = 2'd2;

    localparam count_t   COUNT_FULL = count_t'(NUM_DIGITS);
    localparam reg_idx_t REG_COUNT  = reg_idx_t'(NUM_DIGITS);

    localparam code_t CODE_RESET = {4'd0, 4'd2, 4'd5, 4'd5, 4'd5, 4'd5};

    // matrix key number to entered digit
    localparam digit_sel_t PRESS_DIGIT [0:31] = '{
        1:  '{1'b1, 4'd1},
        2:  '{1'b1, 4'd2},
        3:  '{1'b1, 4'd3},
        5:  '{1'b1, 4'd4},
        6:  '{1'b1, 4'd5},
        7:  '{1'b1, 4'd6},
        9:  '{1'b1, 4'd7},
        10: '{1'b1, 4'd8},
        11: '{1'b1, 4'd9},
        14: '{1'b1, 4'd0},
        default: '{1'b0, 4'd0}
    };

endpackage

### rtl/core/kpl_ifs.sv
// handshake channels for key codes, lock status and code writes

interface kpl_key_if;
    logic          valid;
    logic          ready;
    kpl_pkg::key_t key_code;

    modport source (output valid, output key_code, input ready);
    modport sink   (input valid, input key_code, output ready);
endinterface

interface kpl_status_if;
    logic            valid;
    logic            ready;
    logic            locked;
    kpl_pkg::count_t digits_entered;
    kpl_pkg::check_t check_result;

    modport source (output valid, output locked, output digits_entered,
                    output check_result, input ready);
    modport sink   (input valid, input locked, input digits_entered,
                    input check_result, output ready);
endinterface

interface kpl_cfg_if;
    logic              valid;
    logic              ready;
    kpl_pkg::reg_idx_t index;
    kpl_pkg::digit_t   data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/kpl_code_regs.sv
// unlock code registers written over the config channel
module kpl_code_regs (
    input  logic                clk,
    input  logic                rst_n,
    kpl_cfg_if.sink             cfg,
    output kpl_pkg::code_t      code
);

    kpl_pkg::code_t code_reg;

    assign cfg.ready = 1'b1;
    assign code      = code_reg;

    // writes beyond the last digit are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg <= kpl_pkg::CODE_RESET;
        end
        else if (cfg.valid && (cfg.index < kpl_pkg::REG_COUNT))
        begin
            code_reg[cfg.index] <= cfg.data;
        end
    end

endmodule

### rtl/core/kpl_press.sv
// input register forming the key press from new and previous codes
module kpl_press (
    input  logic                 clk,
    input  logic                 rst_n,
    kpl_key_if.sink              key,
    output kpl_pkg::press_beat_t beat,
    input  logic                 beat_ready
);

    kpl_pkg::key_t prev_reg;
    kpl_pkg::key_t press_reg;
    logic          valid_reg;
    logic          take;

    assign key.ready = !valid_reg || beat_ready;
    assign take      = key.valid && key.ready;

    assign beat.valid = valid_reg;
    assign beat.press = press_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                prev_reg <= key.key_code;
            end
            if (take)
            begin
                valid_reg <= 1'b1;
            end
            else if (beat_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // press is new and changed bits, bitwise
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            press_reg <= key.key_code & (key.key_code ^ prev_reg);
        end
    end

endmodule

### rtl/core/kpl_lock_core.sv
// digit store, entry count, lock state and code compare with result register
module kpl_lock_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  kpl_pkg::press_beat_t beat,
    output logic                 beat_ready,
    input  kpl_pkg::code_t       code,
    kpl_status_if.source         status
);

    kpl_pkg::code_t     store_reg;
    kpl_pkg::code_t     store_next;
    kpl_pkg::count_t    count_reg;
    kpl_pkg::count_t    count_next;
    logic               lock_reg;
    logic               lock_next;
    kpl_pkg::check_t    check_next;
    kpl_pkg::digit_sel_t sel;

    logic               out_valid_reg;
    logic               out_locked_reg;
    kpl_pkg::count_t    out_count_reg;
    kpl_pkg::check_t    out_check_reg;
    logic               take;

    assign beat_ready = !out_valid_reg || status.ready;
    assign take       = beat.valid && beat_ready;

    assign status.valid          = out_valid_reg;
    assign status.locked         = out_locked_reg;
    assign status.digits_entered = out_count_reg;
    assign status.check_result   = out_check_reg;

    assign sel = kpl_pkg::PRESS_DIGIT[beat.press];

    always_comb
    begin
        store_next = store_reg;
        count_next = count_reg;
        lock_next  = lock_reg;
        check_next = kpl_pkg::CHECK_NONE;
        if (sel.hit)
        begin
            // full store ignores further digits
            if (count_reg < kpl_pkg::COUNT_FULL)
            begin
                store_next[count_reg] = sel.value;
                count_next            = count_reg + 3'd1;
            end
        end
        else if (beat.press == kpl_pkg::KEY_CLEAR)
        begin
            count_next = '0;
            lock_next  = 1'b1;
        end
        else if (beat.press == kpl_pkg::KEY_CHECK)
        begin
            // all six entries compared, stale ones included
            if (store_reg == code)
            begin
                lock_next  = 1'b0;
                check_next = kpl_pkg::CHECK_ACCEPT;
            end
            else
            begin
                lock_next  = 1'b1;
                count_next = '0;
                check_next = kpl_pkg::CHECK_REJECT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_reg     <= '0;
            count_reg     <= '0;
            lock_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                store_reg <= store_next;
                count_reg <= count_next;
                lock_reg  <= lock_next;
            end
            if (take)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (status.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_locked_reg <= lock_next;
            out_count_reg  <= count_next;
            out_check_reg  <= check_next;
        end
    end

endmodule

### rtl/core/keypad_pin_lock.sv
// keypad pin lock: one status beat per key code beat
// throughput one key beat per cycle while status is not stalled, set by the press register and result register
// an accepted key beat passes through the press register and then the result register to status
// code writes are registered, cfg ready is always high
// rst_n async low: locked, store and count zero, previous key zero, code 555520
module keypad_pin_lock (
    input  logic         clk,
    input  logic         rst_n,
    kpl_key_if.sink      key,
    kpl_status_if.source status,
    kpl_cfg_if.sink      cfg
);

    `include "assert_macros.svh"

    kpl_pkg::code_t       code;
    kpl_pkg::press_beat_t beat;
    logic                 beat_ready;

    kpl_code_regs u_code_regs (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .code  (code)
    );

    kpl_press u_press (
        .clk        (clk),
        .rst_n      (rst_n),
        .key        (key),
        .beat       (beat),
        .beat_ready (beat_ready)
    );

    kpl_lock_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (beat),
        .beat_ready (beat_ready),
        .code       (code),
        .status     (status)
    );

    `KPL_ASSERT(a_count_range, clk, rst_n, status.valid |-> (status.digits_entered <= kpl_pkg::COUNT_FULL), "digit count above six")
    `KPL_ASSERT(a_accept_unlocks, clk, rst_n, (status.valid && (status.check_result == kpl_pkg::CHECK_ACCEPT)) |-> !status.locked, "accepted code left lock closed")
    `KPL_ASSERT(a_reject_clears, clk, rst_n, (status.valid && (status.check_result == kpl_pkg::CHECK_REJECT)) |-> (status.locked && (status.digits_entered == '0)), "rejected code did not lock and clear")
    `KPL_ASSERT_NEXT(a_press_to_status, clk, rst_n, beat.valid && beat_ready, status.valid, "press beat produced no status beat")

endmodule
